// ===== src/hrf_pkg.sv =====
package hrf_pkg;

   // default width of the body length counter and accumulator
   localparam int unsigned LEN_BITS_DEF = 32;

   // length of the content-length header name
   localparam int unsigned NAME_LEN = 14;

   // byte codes
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // region tags of a result
   localparam logic [2:0] RG_METHOD  = 3'd0;
   localparam logic [2:0] RG_PATH    = 3'd1;
   localparam logic [2:0] RG_VERSION = 3'd2;
   localparam logic [2:0] RG_BREAK   = 3'd3;
   localparam logic [2:0] RG_HEADER  = 3'd4;
   localparam logic [2:0] RG_TERM    = 3'd5;
   localparam logic [2:0] RG_BODY    = 3'd6;
   localparam logic [2:0] RG_EXCESS  = 3'd7;

   // request framing phase
   typedef enum logic [2:0] {
      PH_METHOD,
      PH_PATH,
      PH_VERSION,
      PH_HEADERS,
      PH_BODY,
      PH_DONE
   } phase_type;

   // line break tracking
   typedef enum logic [1:0] {
      NL_MID,
      NL_LF,
      NL_LFCR
   } newline_type;

   // content-length line scanner
   typedef enum logic [2:0] {
      SC_SKIP,
      SC_NAME,
      SC_VBLANK,
      SC_DIGITS,
      SC_IGNORE,
      SC_OK,
      SC_BAD
   } scan_type;

   // one request on the input channel
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       conn_closed;
   } req_type;

   // one result on the output channel
   typedef struct packed {
      logic [2:0]  region;
      logic        path_valid;
      logic        length_found;
      logic [31:0] content_length;
      logic        done_res;
   } rsp_type;

   // lower-case characters of "content-length"
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6f; // o
         4'd2:    ch = 8'h6e; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6e; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2d; // -
         4'd8:    ch = 8'h6c; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6e; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/http_request_framer_core.sv =====
// channel   ports                         payload
// request   req_valid req_ready req_data  rx_byte, conn_closed
// result    rsp_valid rsp_ready rsp_data  region, path_valid, length_found,
//                                         content_length, done_res
//
// one request per cycle while no waiting result stalls; each result appears in the cycle after its request is taken
// the running state is updated in the cycle a request is taken, result goes to a register
// a waiting result stalls new requests only while rsp_ready is low
// reset clears all framing state; a request with conn_closed set also clears it after use
module http_request_framer_core #(
   parameter int unsigned LEN_BITS = hrf_pkg::LEN_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hrf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hrf_pkg::rsp_type rsp_data
);
   import hrf_pkg::*;

   logic                accept;
   logic                scan_en;
   logic                found;
   logic [LEN_BITS-1:0] length;
   rsp_type             result;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   // handshake
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   hrf_length_scan #(
      .LEN_BITS (LEN_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (scan_en),
      .clear       (accept && req_data.conn_closed),
      .rx_byte     (req_data.rx_byte),
      .found_next  (found),
      .length_next (length)
   );

   hrf_framer #(
      .LEN_BITS (LEN_BITS)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .found   (found),
      .length  (length),
      .scan_en (scan_en),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a taken request always leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("taken request produced no result");

   // completion only on a terminator or body byte
   a_done_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |->
         (rsp_data_ff.region == RG_TERM) || (rsp_data_ff.region == RG_BODY))
      else $error("done raised outside terminator or body");

   // a nonzero length needs a parsed header
   a_length_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.content_length != 32'd0) |-> rsp_data_ff.length_found)
      else $error("length reported without a parsed header");

   // version bytes only follow two spaces
   a_version_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.region == RG_VERSION) |-> rsp_data_ff.path_valid)
      else $error("version region without a valid path");

endmodule

// ===== src/hrf_length_scan.sv =====
module hrf_length_scan #(
   parameter int unsigned LEN_BITS = hrf_pkg::LEN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                clear,
   input  logic [7:0]          rx_byte,
   output logic                found_next,
   output logic [LEN_BITS-1:0] length_next
);
   import hrf_pkg::*;

   scan_type            state_ff, state_in;
   logic [3:0]          index_ff, index_in;
   logic [LEN_BITS-1:0] accum_ff, accum_in;

   logic [7:0]          lc;
   logic                blank;
   logic                digit;
   logic [LEN_BITS-1:0] digit_val;
   logic [LEN_BITS+3:0] accum_x10;

   // byte classification
   always_comb begin
      lc        = (rx_byte inside {[CH_UP_A:CH_UP_Z]}) ? rx_byte + CASE_GAP : rx_byte;
      blank     = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
      digit     = rx_byte inside {[CH_ZERO:CH_NINE]};
      digit_val = LEN_BITS'(rx_byte - CH_ZERO);
   end

   // accumulator times ten plus digit, with headroom to spot overflow
   assign accum_x10 = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                      + {4'b0, digit_val};

   // scanner next state
   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      accum_in = accum_ff;
      case (state_ff)
         SC_SKIP: begin
            if (rx_byte != CH_LF && !blank) begin
               if (lc == name_char(4'd0)) begin
                  state_in = SC_NAME;
                  index_in = 4'd1;
               end else begin
                  state_in = SC_IGNORE;
               end
            end
         end
         SC_NAME: begin
            if (rx_byte == CH_LF) begin
               state_in = SC_SKIP;
               index_in = 4'd0;
            end else if (index_ff < 4'(NAME_LEN) && lc == name_char(index_ff)) begin
               index_in = index_ff + 4'd1;
            end else if (index_ff >= 4'(NAME_LEN) && rx_byte == CH_COLON) begin
               state_in = SC_VBLANK;
            end else begin
               state_in = SC_IGNORE;
            end
         end
         SC_IGNORE: begin
            if (rx_byte == CH_LF) begin
               state_in = SC_SKIP;
               index_in = 4'd0;
            end
         end
         SC_VBLANK: begin
            if (!blank) begin
               if (digit) begin
                  state_in = SC_DIGITS;
                  accum_in = digit_val;
               end else begin
                  state_in = SC_BAD;
               end
            end
         end
         SC_DIGITS: begin
            if (digit) begin
               if (accum_x10[LEN_BITS+3:LEN_BITS] != 4'd0) begin
                  state_in = SC_BAD;
                  accum_in = '0;
               end else begin
                  accum_in = accum_x10[LEN_BITS-1:0];
               end
            end else begin
               state_in = SC_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // values after this request, as the framer sees them
   always_comb begin
      if (step_en) begin
         found_next = (state_in == SC_DIGITS) || (state_in == SC_OK);
         length_next = found_next ? accum_in : '0;
      end else begin
         found_next = (state_ff == SC_DIGITS) || (state_ff == SC_OK);
         length_next = found_next ? accum_ff : '0;
      end
   end

   // scanner registers
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff <= SC_SKIP;
         index_ff <= 4'd0;
         accum_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         index_ff <= index_in;
         accum_ff <= accum_in;
      end
   end

endmodule

// ===== src/hrf_framer.sv =====
module hrf_framer #(
   parameter int unsigned LEN_BITS = hrf_pkg::LEN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  hrf_pkg::req_type    req,
   input  logic                found,
   input  logic [LEN_BITS-1:0] length,
   output logic                scan_en,
   output hrf_pkg::rsp_type    result
);
   import hrf_pkg::*;

   localparam int unsigned CL_BITS = (LEN_BITS < 32) ? LEN_BITS : 32;

   phase_type           phase_ff, phase_in;
   logic [1:0]          space_ff, space_in;
   newline_type         nl_ff, nl_in;
   logic [LEN_BITS-1:0] body_ff, body_in;

   logic                in_head;
   logic                term;
   logic [LEN_BITS-1:0] body_inc;
   logic                body_hit;

   // terminator and body count detection
   always_comb begin
      in_head  = phase_ff inside {PH_METHOD, PH_PATH, PH_VERSION, PH_HEADERS};
      term     = in_head && (req.rx_byte == CH_LF) && (nl_ff != NL_MID);
      scan_en  = accept && in_head && !term;
      body_inc = body_ff + 1'b1;
      body_hit = body_inc == length;
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      space_in = space_ff;
      nl_in    = nl_ff;
      body_in  = body_ff;
      if (in_head) begin
         if (term) begin
            body_in  = '0;
            phase_in = (length == '0) ? PH_DONE : PH_BODY;
         end else if (req.rx_byte == CH_LF) begin
            nl_in = NL_LF;
            if (phase_ff != PH_HEADERS) begin
               phase_in = PH_HEADERS;
            end
         end else if (req.rx_byte == CH_CR) begin
            nl_in = (nl_ff == NL_LF) ? NL_LFCR : NL_MID;
         end else begin
            nl_in = NL_MID;
            if (req.rx_byte == CH_SPACE) begin
               if (phase_ff == PH_METHOD) begin
                  space_in = 2'd1;
                  phase_in = PH_PATH;
               end else if (phase_ff == PH_PATH) begin
                  space_in = 2'd2;
                  phase_in = PH_VERSION;
               end
            end
         end
      end else if (phase_ff == PH_BODY) begin
         body_in = body_inc;
         if (body_hit) begin
            phase_in = PH_DONE;
         end
      end
   end

   // result fields
   always_comb begin
      result.region   = RG_EXCESS;
      result.done_res = 1'b0;
      if (in_head) begin
         if (term) begin
            result.region   = RG_TERM;
            result.done_res = (length == '0);
         end else if (req.rx_byte == CH_LF || req.rx_byte == CH_CR) begin
            result.region = RG_BREAK;
         end else begin
            case (phase_ff)
               PH_METHOD:  result.region = RG_METHOD;
               PH_PATH:    result.region = RG_PATH;
               PH_VERSION: result.region = RG_VERSION;
               default:    result.region = RG_HEADER;
            endcase
         end
      end else if (phase_ff == PH_BODY) begin
         result.region   = RG_BODY;
         result.done_res = body_hit;
      end
      result.path_valid     = (space_in == 2'd2);
      result.length_found   = found;
      result.content_length = 32'(length[CL_BITS-1:0]);
   end

   // framing registers, cleared after the last byte of a connection
   always_ff @(posedge clock) begin
      if (reset || (accept && req.conn_closed)) begin
         phase_ff <= PH_METHOD;
         space_ff <= 2'd0;
         nl_ff    <= NL_LF;
         body_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         space_ff <= space_in;
         nl_ff    <= nl_in;
         body_ff  <= body_in;
      end
   end

endmodule

// ===== dv/http_request_framer_checker.sv =====
module http_request_framer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hrf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hrf_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import hrf_pkg::*;

   localparam logic [8*NAME_LEN-1:0] CL_NAME = "content-length";
   localparam logic [31:0]           LEN_MAX = 32'hffff_ffff;

   // framing state of the predictor
   phase_type   ph;
   logic [1:0]  spaces;
   newline_type nl;
   scan_type    scan;
   logic [3:0]  name_idx;
   logic [31:0] acc;
   logic [31:0] body_cnt;

   // predicted tags still to come out of the block
   rsp_type     tag_queue[$];
   int          bad_count  = 0;
   int          result_idx = 0;

   function automatic logic [7:0] name_byte(input logic [3:0] i);
      return CL_NAME[8*(NAME_LEN-1-i) +: 8];
   endfunction

   function automatic logic length_seen();
      return scan == SC_DIGITS || scan == SC_OK;
   endfunction

   function automatic logic [31:0] live_length();
      return length_seen() ? acc : 32'd0;
   endfunction

   task clear_framing();
      ph       = PH_METHOD;
      spaces   = 2'd0;
      nl       = NL_LF;
      scan     = SC_SKIP;
      name_idx = 4'd0;
      acc      = 32'd0;
      body_cnt = 32'd0;
   endtask

   // content-length line scanner, one byte
   task scan_line_byte(input logic [7:0] b);
      logic [7:0]  lc;
      logic        blank;
      logic        digit;
      logic [31:0] d;
      lc    = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
      blank = (b == CH_SPACE || b == CH_TAB);
      digit = (b >= CH_ZERO && b <= CH_NINE);
      d     = {24'd0, b - CH_ZERO};
      case (scan)
         SC_SKIP: begin
            if (!(b == CH_LF || blank)) begin
               if (lc == name_byte(4'd0)) begin
                  scan     = SC_NAME;
                  name_idx = 4'd1;
               end else begin
                  scan = SC_IGNORE;
               end
            end
         end
         SC_NAME: begin
            if (b == CH_LF) begin
               scan     = SC_SKIP;
               name_idx = 4'd0;
            end else if (name_idx < NAME_LEN && lc == name_byte(name_idx)) begin
               name_idx = name_idx + 4'd1;
            end else if (name_idx >= NAME_LEN && b == CH_COLON) begin
               scan = SC_VBLANK;
            end else begin
               scan = SC_IGNORE;
            end
         end
         SC_IGNORE: begin
            if (b == CH_LF) begin
               scan     = SC_SKIP;
               name_idx = 4'd0;
            end
         end
         SC_VBLANK: begin
            if (!blank) begin
               if (digit) begin
                  scan = SC_DIGITS;
                  acc  = d;
               end else begin
                  scan = SC_BAD;
               end
            end
         end
         SC_DIGITS: begin
            if (digit) begin
               // would the next digit overflow the counter
               if (acc > (LEN_MAX - d) / 32'd10) begin
                  scan = SC_BAD;
                  acc  = 32'd0;
               end else begin
                  acc = acc * 32'd10 + d;
               end
            end else begin
               scan = SC_OK;
            end
         end
         default: ;
      endcase
   endtask

   // region tag and flags for one request byte
   task tag_byte(input req_type r, output rsp_type t);
      logic [7:0] b;
      logic [2:0] rg;
      logic       fin;
      b   = r.rx_byte;
      rg  = RG_EXCESS;
      fin = 1'b0;
      if (ph <= PH_HEADERS) begin
         if (b == CH_LF && nl != NL_MID) begin
            // blank line ends the header block
            rg       = RG_TERM;
            body_cnt = 32'd0;
            if (live_length() == 32'd0) begin
               fin = 1'b1;
               ph  = PH_DONE;
            end else begin
               ph = PH_BODY;
            end
         end else begin
            scan_line_byte(b);
            if (b == CH_LF) begin
               rg = RG_BREAK;
               nl = NL_LF;
               if (ph < PH_HEADERS) ph = PH_HEADERS;
            end else if (b == CH_CR) begin
               rg = RG_BREAK;
               nl = (nl == NL_LF) ? NL_LFCR : NL_MID;
            end else begin
               nl = NL_MID;
               case (ph)
                  PH_METHOD: begin
                     rg = RG_METHOD;
                     if (b == CH_SPACE) begin
                        spaces = 2'd1;
                        ph     = PH_PATH;
                     end
                  end
                  PH_PATH: begin
                     rg = RG_PATH;
                     if (b == CH_SPACE) begin
                        spaces = 2'd2;
                        ph     = PH_VERSION;
                     end
                  end
                  PH_VERSION: rg = RG_VERSION;
                  default:    rg = RG_HEADER;
               endcase
            end
         end
      end else if (ph == PH_BODY) begin
         rg       = RG_BODY;
         body_cnt = body_cnt + 32'd1;
         if (body_cnt == live_length()) begin
            fin = 1'b1;
            ph  = PH_DONE;
         end
      end
      t.region         = rg;
      t.path_valid     = (spaces == 2'd2);
      t.length_found   = length_seen();
      t.content_length = live_length();
      t.done_res       = fin;
      if (r.conn_closed) clear_framing();
   endtask

   // compare results in order, then predict the request taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    differs;
      if (reset) begin
         clear_framing();
         tag_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (tag_queue.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("result %0d arrived with nothing predicted: region %0d",
                           result_idx, got.region);
            end else begin
               want    = tag_queue.pop_front();
               differs = (want.region !== got.region)
                      || (want.path_valid !== got.path_valid)
                      || (want.length_found !== got.length_found)
                      || (want.content_length !== got.content_length)
                      || (want.done_res !== got.done_res);
               if (differs) begin
                  bad_count++;
                  if (bad_count <= 10) begin
                     $display("result %0d mismatch", result_idx);
                     $display("  expected region %0d path %0b found %0b length %0d done %0b",
                              want.region, want.path_valid, want.length_found,
                              want.content_length, want.done_res);
                     $display("  actual   region %0d path %0b found %0b length %0d done %0b",
                              got.region, got.path_valid, got.length_found,
                              got.content_length, got.done_res);
                  end
               end
            end
            result_idx++;
         end
         if (req_valid && req_ready) begin
            tag_byte(req_data, want);
            tag_queue.push_back(want);
         end
      end
      mismatches  <= bad_count;
      outstanding <= tag_queue.size();
   end

endmodule

// ===== dv/http_request_framer_core_tb.sv =====
module http_request_framer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hrf_pkg::*;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;

   req_type byte_stream[$];
   int      directed_len;
   bit      req_burst = 1'b0;
   bit      rsp_burst = 1'b0;

   http_request_framer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   http_request_framer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // request byte building
   task put_byte(input logic [7:0] b);
      byte_stream.push_back(req_type'{rx_byte: b, conn_closed: 1'b0});
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task close_here();
      byte_stream[byte_stream.size()-1].conn_closed = 1'b1;
   endtask

   task put_eol(input bit crlf);
      if (crlf) put_byte(CH_CR);
      put_byte(CH_LF);
   endtask

   task put_blank();
      put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   function automatic logic [7:0] text_char();
      return 8'($urandom_range(8'h21, 8'h7e));
   endfunction

   // one content-length line, sometimes malformed
   task automatic put_length_line(input bit crlf, output bit decides, output longint value);
      string      nm = "content-length";
      logic [7:0] ch;
      int         miss;
      int         vk;
      int         dg;
      value = 0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_blank();
      miss = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < ((miss == 1) ? 13 : 14); i++) begin
         ch = nm[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - CASE_GAP;
         put_byte(ch);
      end
      if (miss == 2) put_byte("x");
      if (miss == 3) put_byte(CH_SPACE);
      put_byte(CH_COLON);
      decides = (miss == 0);
      repeat ($urandom_range(0, 2)) put_blank();
      vk = $urandom_range(0, 15);
      case (vk)
         0: if ($urandom_range(0, 1)) put_byte("x");
         1: begin
            put_text("4294967295");
            value = 64'd4294967295;
         end
         2: put_text("4294967296");
         3: put_text("123456789012");
         4: begin
            dg = $urandom_range(0, 9);
            put_text($sformatf("000%0d", dg));
            value = dg;
         end
         default: begin
            value = $urandom_range(0, 24);
            put_text($sformatf("%0d", value));
         end
      endcase
      if ($urandom_range(0, 3) == 0) put_text(" ;x");
      put_eol(crlf);
   endtask

   // one request: mostly well formed with random content, some noise
   task automatic build_request();
      int     kind;
      int     n;
      int     start;
      int     cut;
      int     pick;
      bit     crlf;
      bit     decided;
      bit     dec;
      longint len;
      longint v;
      start = byte_stream.size();
      kind  = $urandom_range(0, 19);
      crlf  = $urandom_range(0, 1);
      // raw noise with random closes
      if (kind < 2) begin
         repeat ($urandom_range(1, 30)) begin
            put_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 15) == 0) close_here();
         end
         close_here();
         return;
      end
      // empty request line
      if (kind == 2) begin
         put_eol(crlf);
         repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
         close_here();
         return;
      end
      // request line, occasionally short of spaces or with extra ones
      repeat ($urandom_range(1, 7)) put_byte(8'($urandom_range(CH_UP_A, CH_UP_Z)));
      n = $urandom_range(0, 9);
      if (n != 0) begin
         put_byte(CH_SPACE);
         put_byte("/");
         repeat ($urandom_range(0, 6)) put_byte(text_char());
      end
      if (n > 1) begin
         put_byte(CH_SPACE);
         put_text("HTTP/1.1");
         if (n == 9) put_text(" x y");
      end
      if ($urandom_range(0, 15) == 0) put_byte(CH_CR);
      put_eol(crlf);
      // header lines
      decided = 1'b0;
      len     = 0;
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 2) == 0 || (!decided && $urandom_range(0, 1))) begin
            put_length_line(crlf, dec, v);
            if (dec && !decided) begin
               decided = 1'b1;
               len     = v;
            end
         end else begin
            put_byte("X");
            repeat ($urandom_range(1, 5)) put_byte(text_char());
            put_byte(CH_COLON);
            put_byte(CH_SPACE);
            repeat ($urandom_range(0, 8)) begin
               pick = $urandom_range(0, 11);
               case (pick)
                  0:       put_byte(CH_CR);
                  1:       put_byte(CH_TAB);
                  2:       put_byte(CH_SPACE);
                  default: put_byte(text_char());
               endcase
            end
            put_eol(crlf);
         end
      end
      // blank line, sometimes after a doubled cr that does not end the headers
      if ($urandom_range(0, 11) == 0) begin
         put_byte(CH_CR);
         put_byte(CH_CR);
         put_byte(CH_LF);
      end
      put_eol(crlf);
      // body then a few excess bytes
      n = (len > 40) ? $urandom_range(0, 6) : int'(len);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
      // connection dropped part way through
      if ($urandom_range(0, 14) == 0) begin
         cut = $urandom_range(start, byte_stream.size() - 1);
         while (byte_stream.size() > cut + 1) void'(byte_stream.pop_back());
      end
      if ($urandom_range(0, 19) != 0) close_here();
   endtask

   // result side: random stall before each result
   initial begin
      int gap;
      int taken;
      taken = 0;
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 12);
         @(negedge clock);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // request side and verdict
   initial begin
      int gap;
      // directed: empty request line first, then a request-line length header
      put_byte(CH_LF);
      put_byte(8'hff);
      close_here();
      put_text("Content-Length:");
      put_byte(CH_TAB);
      put_text("2 ");
      put_byte(CH_CR);
      put_byte(CH_LF);
      put_byte(CH_CR);
      put_byte(CH_LF);
      put_text("xyz");
      close_here();
      directed_len = byte_stream.size();
      while (byte_stream.size() < directed_len + 1400) build_request();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < byte_stream.size(); i++) begin
         // hold off until the block has drained
         if (i == directed_len || i == byte_stream.size() / 2) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         gap = req_burst ? 0 : $urandom_range(0, 12);
         @(negedge clock);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= byte_stream[i];
         do @(posedge clock); while (!req_ready);
         if (i % 64 == 63) req_burst = ($urandom_range(0, 3) == 0);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hrf_pkg.sv
src/hrf_length_scan.sv
src/hrf_framer.sv
src/http_request_framer_core.sv
dv/http_request_framer_checker.sv
dv/http_request_framer_core_tb.sv
